>>> hw/rtl/stb_pkg.sv
// Shared types and constants for the sequenced trace ring buffer.
// Used by stb_ctrl, stb_dp and the top level; depends on nothing.
`default_nettype none

package stb_pkg;

   localparam int DEPTH        = 32;
   localparam int PAYLOAD_BITS = 32;
   localparam int SEQ_BITS     = 32;
   localparam int DATA_BITS    = 32;
   localparam int CAP_BITS     = 6;
   localparam int MAX_BITS     = 6;
   localparam int IDX_BITS     = $clog2(DEPTH);
   localparam int CNT_BITS     = $clog2(DEPTH + 1);
   localparam int ENTRY_BITS   = SEQ_BITS + PAYLOAD_BITS;

   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(32);
   localparam logic [SEQ_BITS-1:0] SEQ_FIRST = SEQ_BITS'(1);
   localparam logic [SEQ_BITS-1:0] SEQ_MAX   = '1;
   localparam logic [SEQ_BITS-1:0] SEQ_NONE  = '0;

   localparam logic FUNC_APPEND = 1'b0;
   localparam logic FUNC_READ   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_PLAN,
      ST_STREAM
   } stb_state_type;

   typedef struct packed {
      logic append;      // store payload, emit assigned number
      logic lookup;      // latch read request, fetch oldest entry
      logic measure;     // compare since against oldest entry
      logic plan;        // size the answer, set the stream start
      logic emit_empty;  // answer carries no event
      logic fetch;       // read one stored entry into the output stage
   } stb_cmd_type;

   typedef struct packed {
      logic out_free;    // output stage empty or draining this cycle
      logic plan_empty;  // no event to return
      logic last_fetch;  // one entry left to stream
   } stb_status_type;

endpackage

`default_nettype wire

>>> hw/rtl/stb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Self-contained; no package needed.
`default_nettype none

module stb_ram #(
   parameter int WIDTH = 8,
   parameter int WORDS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(WORDS)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(WORDS)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [WORDS];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/stb_ctrl.sv
// Sequencer for the trace ring buffer: accepts requests, steps a read
// through lookup, sizing and streaming. Uses stb_pkg.
`default_nettype none

module stb_ctrl
   import stb_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic           req_func,
   input  stb_status_type      status,
   output logic                req_stall,
   output stb_cmd_type         cmd
);

   stb_state_type state_ff;
   stb_state_type state_in;
   logic          accept;

   assign accept    = (state_ff == ST_IDLE) && req_valid && status.out_free;
   assign req_stall = !((state_ff == ST_IDLE) && status.out_free);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_func == FUNC_READ)) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_PLAN;
         end
         ST_PLAN: begin
            state_in = status.plan_empty ? ST_IDLE : ST_STREAM;
         end
         ST_STREAM: begin
            if (status.out_free && status.last_fetch) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.append = accept && (req_func == FUNC_APPEND);
            cmd.lookup = accept && (req_func == FUNC_READ);
         end
         ST_LOOK: begin
            cmd.measure = 1'b1;
         end
         ST_PLAN: begin
            cmd.plan       = 1'b1;
            cmd.emit_empty = status.plan_empty;
         end
         ST_STREAM: begin
            cmd.fetch = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/stb_dp.sv
// Datapath of the trace ring buffer: entry store, counters, read sizing
// and the output stage. Uses stb_pkg and stb_ram.
`default_nettype none

module stb_dp
   import stb_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  stb_cmd_type                  cmd,
   output stb_status_type               status,
   input  wire logic [DATA_BITS-1:0]    req_payload,
   input  wire logic [SEQ_BITS-1:0]     req_since_seq,
   input  wire logic [MAX_BITS-1:0]     req_max_events,
   input  wire logic                    csr_write_en,
   input  wire logic [CAP_BITS-1:0]     csr_write_data,
   input  wire logic                    rsp_stall,
   output logic                         rsp_valid,
   output logic      [SEQ_BITS-1:0]     rsp_seq,
   output logic      [DATA_BITS-1:0]    rsp_event_data,
   output logic                         rsp_has_event,
   output logic                         rsp_gap,
   output logic      [SEQ_BITS-1:0]     rsp_last_seq,
   output logic                         rsp_last
);

   // control state
   logic [CAP_BITS-1:0] cap_ff, cap_in;
   logic [IDX_BITS-1:0] wp_ff, wp_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [SEQ_BITS-1:0] next_seq_ff, next_seq_in;
   logic [SEQ_BITS-1:0] newest_seq_ff, newest_seq_in;
   logic                rv_ff, rv_in;   // register-sourced result pending
   logic                fv_ff, fv_in;   // fetched entry pending in RAM output

   // per-read working registers
   logic [SEQ_BITS-1:0] since_ff, since_in;
   logic [MAX_BITS-1:0] max_ff, max_in;
   logic [IDX_BITS-1:0] oldest_idx_ff, oldest_idx_in;
   logic [SEQ_BITS-1:0] oldest_seq_ff, oldest_seq_in;
   logic [CNT_BITS-1:0] jclip_ff, jclip_in;
   logic [CNT_BITS-1:0] elig_ff, elig_in;
   logic [CNT_BITS-1:0] remaining_ff, remaining_in;
   logic [IDX_BITS-1:0] rd_idx_ff, rd_idx_in;
   logic                flast_ff, flast_in;
   logic                gap_ff, gap_in;
   logic [SEQ_BITS-1:0] last_seq_ff, last_seq_in;
   logic [SEQ_BITS-1:0] out_seq_ff, out_seq_in;

   // RAM port
   logic                  ram_wr_en;
   logic [ENTRY_BITS-1:0] ram_wr_data;
   logic                  ram_rd_en;
   logic [IDX_BITS-1:0]   ram_rd_addr;
   logic [ENTRY_BITS-1:0] ram_rd_data;
   logic [SEQ_BITS-1:0]   ram_seq;
   logic [PAYLOAD_BITS-1:0] ram_payload;

   // combinational helpers
   logic [CNT_BITS-1:0] eff_cap;
   logic [CNT_BITS:0]   count_inc;
   logic [CNT_BITS:0]   oldest_sum;
   logic [IDX_BITS-1:0] oldest_idx;
   logic                since_ge;
   logic [SEQ_BITS:0]   j_big;
   logic [CNT_BITS-1:0] jclip;
   logic                gap_now;
   logic                trunc;
   logic [CNT_BITS-1:0] n_events;
   logic [CNT_BITS:0]   last_pos;
   logic [SEQ_BITS:0]   last_pos_seq;
   logic [SEQ_BITS-1:0] plan_last_seq;
   logic [CNT_BITS:0]   start_sum;
   logic                out_busy;

   assign ram_seq     = ram_rd_data[PAYLOAD_BITS +: SEQ_BITS];
   assign ram_payload = ram_rd_data[PAYLOAD_BITS-1:0];

   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CNT_BITS'(1);
      end else if (32'(cap_ff) > 32'(DEPTH)) begin
         eff_cap = CNT_BITS'(DEPTH);
      end else begin
         eff_cap = CNT_BITS'(cap_ff);
      end
   end

   assign count_inc = {1'b0, count_ff} + (CNT_BITS + 1)'(1);

   // oldest slot = write pointer minus count, modulo the depth
   always_comb begin
      if ({1'b0, count_ff} > (CNT_BITS + 1)'(wp_ff)) begin
         oldest_sum = (CNT_BITS + 1)'(wp_ff) + (CNT_BITS + 1)'(DEPTH) - {1'b0, count_ff};
      end else begin
         oldest_sum = (CNT_BITS + 1)'(wp_ff) - {1'b0, count_ff};
      end
   end
   assign oldest_idx = oldest_sum[IDX_BITS-1:0];

   // Stored numbers run up by one from the oldest and then stick at the
   // maximum, so the first entry above since sits at since - oldest + 1.
   always_comb begin
      since_ge = since_ff >= ram_seq;
      j_big    = {1'b0, since_ff} - {1'b0, ram_seq} + (SEQ_BITS + 1)'(1);
      if (count_ff == '0) begin
         // empty store: the RAM word at the oldest slot holds no valid entry
         jclip = '0;
      end else if (!since_ge) begin
         jclip = '0;
      end else if ((since_ff == SEQ_MAX) ||
                   (j_big >= (SEQ_BITS + 1)'(count_ff))) begin
         jclip = count_ff;
      end else begin
         jclip = j_big[CNT_BITS-1:0];
      end
      gap_now = (since_ff != SEQ_NONE) && (count_ff != '0) &&
                (({1'b0, since_ff} + (SEQ_BITS + 1)'(1)) < {1'b0, ram_seq});
   end

   always_comb begin
      trunc    = (max_ff != '0) && (32'(elig_ff) > 32'(max_ff));
      n_events = trunc ? CNT_BITS'(max_ff) : elig_ff;
      last_pos = {1'b0, jclip_ff} + {1'b0, n_events} - (CNT_BITS + 1)'(1);
      last_pos_seq = {1'b0, oldest_seq_ff} + (SEQ_BITS + 1)'(last_pos);
      if (!trunc) begin
         plan_last_seq = newest_seq_ff;
      end else if (last_pos_seq[SEQ_BITS]) begin
         plan_last_seq = SEQ_MAX;
      end else begin
         plan_last_seq = last_pos_seq[SEQ_BITS-1:0];
      end
      start_sum = (CNT_BITS + 1)'(oldest_idx_ff) + (CNT_BITS + 1)'(jclip_ff);
      if (start_sum >= (CNT_BITS + 1)'(DEPTH)) begin
         start_sum = start_sum - (CNT_BITS + 1)'(DEPTH);
      end
   end

   assign out_busy          = rv_ff || fv_ff;
   assign status.out_free   = !(out_busy && rsp_stall);
   assign status.plan_empty = (n_events == '0);
   assign status.last_fetch = (remaining_ff == CNT_BITS'(1));

   assign ram_wr_en   = cmd.append;
   assign ram_wr_data = {next_seq_ff, PAYLOAD_BITS'(req_payload)};
   assign ram_rd_en   = cmd.lookup || cmd.fetch;
   assign ram_rd_addr = cmd.lookup ? oldest_idx : rd_idx_ff;

   always_comb begin
      cap_in        = csr_write_en ? csr_write_data : cap_ff;
      wp_in         = wp_ff;
      count_in      = count_ff;
      next_seq_in   = next_seq_ff;
      newest_seq_in = newest_seq_ff;
      since_in      = since_ff;
      max_in        = max_ff;
      oldest_idx_in = oldest_idx_ff;
      oldest_seq_in = oldest_seq_ff;
      jclip_in      = jclip_ff;
      elig_in       = elig_ff;
      remaining_in  = remaining_ff;
      rd_idx_in     = rd_idx_ff;
      flast_in      = flast_ff;
      gap_in        = gap_ff;
      last_seq_in   = last_seq_ff;
      out_seq_in    = out_seq_ff;
      rv_in         = rv_ff && rsp_stall;
      fv_in         = fv_ff && rsp_stall;

      if (cmd.append) begin
         if (next_seq_ff != SEQ_MAX) begin
            next_seq_in = next_seq_ff + SEQ_BITS'(1);
         end
         newest_seq_in = next_seq_ff;
         wp_in = (wp_ff == IDX_BITS'(DEPTH - 1)) ? '0 : wp_ff + IDX_BITS'(1);
         if (count_inc > (CNT_BITS + 1)'(eff_cap)) begin
            count_in = eff_cap;
         end else begin
            count_in = count_inc[CNT_BITS-1:0];
         end
         rv_in       = 1'b1;
         out_seq_in  = next_seq_ff;
         gap_in      = 1'b0;
         last_seq_in = next_seq_ff;
      end

      if (cmd.lookup) begin
         since_in      = req_since_seq;
         max_in        = req_max_events;
         oldest_idx_in = oldest_idx;
      end

      if (cmd.measure) begin
         oldest_seq_in = ram_seq;
         jclip_in      = jclip;
         elig_in       = count_ff - jclip;
         gap_in        = gap_now;
      end

      if (cmd.plan) begin
         last_seq_in  = plan_last_seq;
         remaining_in = n_events;
         rd_idx_in    = start_sum[IDX_BITS-1:0];
      end

      if (cmd.emit_empty) begin
         rv_in      = 1'b1;
         out_seq_in = SEQ_NONE;
      end

      if (cmd.fetch) begin
         fv_in        = 1'b1;
         flast_in     = (remaining_ff == CNT_BITS'(1));
         remaining_in = remaining_ff - CNT_BITS'(1);
         rd_idx_in    = (rd_idx_ff == IDX_BITS'(DEPTH - 1)) ? '0 : rd_idx_ff + IDX_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff        <= CAP_RESET;
         wp_ff         <= '0;
         count_ff      <= '0;
         next_seq_ff   <= SEQ_FIRST;
         newest_seq_ff <= SEQ_NONE;
         rv_ff         <= 1'b0;
         fv_ff         <= 1'b0;
      end else begin
         cap_ff        <= cap_in;
         wp_ff         <= wp_in;
         count_ff      <= count_in;
         next_seq_ff   <= next_seq_in;
         newest_seq_ff <= newest_seq_in;
         rv_ff         <= rv_in;
         fv_ff         <= fv_in;
      end
   end

   always_ff @(posedge clock) begin
      since_ff      <= since_in;
      max_ff        <= max_in;
      oldest_idx_ff <= oldest_idx_in;
      oldest_seq_ff <= oldest_seq_in;
      jclip_ff      <= jclip_in;
      elig_ff       <= elig_in;
      remaining_ff  <= remaining_in;
      rd_idx_ff     <= rd_idx_in;
      flast_ff      <= flast_in;
      gap_ff        <= gap_in;
      last_seq_ff   <= last_seq_in;
      out_seq_ff    <= out_seq_in;
   end

   stb_ram #(
      .WIDTH (ENTRY_BITS),
      .WORDS (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wp_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // fetched entries leave straight from the RAM output register
   assign rsp_valid      = out_busy;
   assign rsp_seq        = fv_ff ? ram_seq : out_seq_ff;
   assign rsp_event_data = fv_ff ? DATA_BITS'(ram_payload) : '0;
   assign rsp_has_event  = fv_ff;
   assign rsp_gap        = gap_ff;
   assign rsp_last_seq   = last_seq_ff;
   assign rsp_last       = fv_ff ? flast_ff : 1'b1;

endmodule

`default_nettype wire

>>> hw/rtl/sequenced_trace_ring_buffer.sv
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_stall  func, payload, since_seq, max_events
// rsp      out        rsp_valid / rsp_stall  seq, event_data, has_event, gap, last_seq, last
// csr      in         csr_write_en           capacity (no read-back)
//
// Append: the result shows in the cycle after the beat; a new beat can be taken every cycle while rsp drains.
// Read: the request beat does the lookup, then ST_LOOK compares and ST_PLAN sizes;
// an empty answer is registered out of ST_PLAN, else ST_STREAM sends one stored entry
// per cycle while rsp drains, set by the single read port of the entry RAM.
// Synchronous active-high reset; store contents are not cleared, no sweep.
// A stalled rsp holds its beat; req stalls while a read is in progress or the output stage cannot move.
// Top level of the sequenced trace ring buffer; uses stb_pkg, stb_ctrl, stb_dp.
`default_nettype none

module sequenced_trace_ring_buffer
   import stb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_func,
   input  wire logic [DATA_BITS-1:0]  req_payload,
   input  wire logic [SEQ_BITS-1:0]   req_since_seq,
   input  wire logic [MAX_BITS-1:0]   req_max_events,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [SEQ_BITS-1:0]   rsp_seq,
   output logic      [DATA_BITS-1:0]  rsp_event_data,
   output logic                       rsp_has_event,
   output logic                       rsp_gap,
   output logic      [SEQ_BITS-1:0]   rsp_last_seq,
   output logic                       rsp_last,
   input  wire logic                  csr_write_en,
   input  wire logic [CAP_BITS-1:0]   csr_write_data
);

   stb_cmd_type    cmd;
   stb_status_type status;

   stb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   stb_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_payload    (req_payload),
      .req_since_seq  (req_since_seq),
      .req_max_events (req_max_events),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_seq        (rsp_seq),
      .rsp_event_data (rsp_event_data),
      .rsp_has_event  (rsp_has_event),
      .rsp_gap        (rsp_gap),
      .rsp_last_seq   (rsp_last_seq),
      .rsp_last       (rsp_last)
   );

`ifndef SYNTH
   // an append answers on the very next cycle with a single closing beat
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_func == FUNC_APPEND))
      |=> (rsp_valid && rsp_last && !rsp_has_event))
      else $error("append result missing or malformed");

   // a read needs lookup cycles, so nothing is shown right after it is taken
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_func == FUNC_READ)) |=> !rsp_valid)
      else $error("beat shown during read lookup");

   // stored events are numbered from one upward
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_has_event) |-> (rsp_seq != SEQ_NONE))
      else $error("event beat without a sequence number");
`endif

endmodule

`default_nettype wire
